/* hdl/rgb565_vignette_filter_top_assert.svh */
// ----------------------------------------------------------------------------
// rgb565_vignette_filter_top_assert.svh
// Assertion macros shared by the vignette filter RTL.
// ----------------------------------------------------------------------------
`ifndef RGB565_VIGNETTE_FILTER_TOP_ASSERT_SVH
`define RGB565_VIGNETTE_FILTER_TOP_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent
`define RVF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent
`define RVF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/rvf_pkg.sv */
// ----------------------------------------------------------------------------
// rvf_pkg
// Shared constants, types and helpers of the RGB565 vignette filter.
// ----------------------------------------------------------------------------
package rvf_pkg;

    // Image geometry
    localparam int MAX_DIM     = 128;
    localparam int LINE_PIXELS = 1024;
    localparam int DIM_W       = $clog2(MAX_DIM + 1);
    localparam int POS_W       = $clog2(MAX_DIM);
    localparam int HALF_W      = $clog2(MAX_DIM / 2 + 1);

    // Field and register widths
    localparam int PIXEL_W    = 16;
    localparam int ADDR_W     = 20;
    localparam int DIM_CFG_W  = 8;
    localparam int ORIGIN_W   = 10;
    localparam int DATA_W     = 32;
    localparam int CFG_ADDR_W = 4;

    // Datapath
    localparam int LUMA_SHIFT  = 22;
    localparam int QUEUE_DEPTH = 2;

    // Register map, word index
    typedef enum logic [1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_ORIGIN_COL   = 2'd2,
        CFG_ORIGIN_ROW   = 2'd3
    } rvf_cfg_t;

    // Classified pixel handed from front to back
    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic [POS_W-1:0]   dx;
        logic [POS_W-1:0]   dy;
        logic [HALF_W-1:0]  cx;
        logic [HALF_W-1:0]  cy;
        logic [ADDR_W-1:0]  address;
        logic               last;
    } rvf_item_t;

    // Queue status
    typedef struct packed {
        logic empty;
        logic full;
    } rvf_qstat_t;

    // Clamp a programmed dimension to 1..MAX_DIM
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_CFG_W-1:0] v);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (int'(v) > MAX_DIM) begin
            res = DIM_W'(MAX_DIM);
        end else begin
            res = DIM_W'(v);
        end
        return res;
    endfunction

endpackage

/* hdl/rvf_front.sv */
// ----------------------------------------------------------------------------
// rvf_front
// Register file and position tracker: classifies each accepted pixel with
// its distance from the image center, VRAM offset and end-of-image flag.
// ----------------------------------------------------------------------------
module rvf_front
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rvf_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [rvf_pkg::DATA_W-1:0]       pwdata,
    output logic [rvf_pkg::DATA_W-1:0]       prdata,
    output logic                             pready,
    input  logic                             pixel_valid,
    output logic                             pixel_ready,
    input  logic [rvf_pkg::PIXEL_W-1:0]      pixel_in,
    input  rvf_pkg::rvf_qstat_t              qstat,
    output logic                             push,
    output rvf_pkg::rvf_item_t               push_item
);

    localparam int DIM_W  = rvf_pkg::DIM_W;
    localparam int POS_W  = rvf_pkg::POS_W;
    localparam int HALF_W = rvf_pkg::HALF_W;

    logic [rvf_pkg::DIM_CFG_W-1:0] width_reg, width_next;
    logic [rvf_pkg::DIM_CFG_W-1:0] height_reg, height_next;
    logic [rvf_pkg::ORIGIN_W-1:0]  ocol_reg, ocol_next;
    logic [rvf_pkg::ORIGIN_W-1:0]  orow_reg, orow_next;
    logic [POS_W-1:0]              col_reg, col_next;
    logic [POS_W-1:0]              row_reg, row_next;

    logic              cfg_wr;
    rvf_pkg::rvf_cfg_t cfg_idx;
    logic              accept;
    logic [DIM_W-1:0]  w_eff, h_eff;
    logic [HALF_W-1:0] cx, cy;
    logic [DIM_W-1:0]  col_ext, row_ext;
    logic              col_end, row_end;
    logic [31:0]       addr_full;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = rvf_pkg::rvf_cfg_t'(paddr[3:2]);

    // Read back the addressed register
    always_comb
    begin
        unique case (cfg_idx)
            rvf_pkg::CFG_IMAGE_WIDTH:  prdata = rvf_pkg::DATA_W'(width_reg);
            rvf_pkg::CFG_IMAGE_HEIGHT: prdata = rvf_pkg::DATA_W'(height_reg);
            rvf_pkg::CFG_ORIGIN_COL:   prdata = rvf_pkg::DATA_W'(ocol_reg);
            rvf_pkg::CFG_ORIGIN_ROW:   prdata = rvf_pkg::DATA_W'(orow_reg);
        endcase
    end

    // Classify the pixel at the current position
    assign pixel_ready = !qstat.full;
    assign accept      = pixel_valid && pixel_ready;
    assign push        = accept;

    assign w_eff   = rvf_pkg::eff_dim(width_reg);
    assign h_eff   = rvf_pkg::eff_dim(height_reg);
    assign cx      = HALF_W'(w_eff >> 1);
    assign cy      = HALF_W'(h_eff >> 1);
    assign col_ext = DIM_W'(col_reg);
    assign row_ext = DIM_W'(row_reg);
    assign col_end = (col_ext + DIM_W'(1)) == w_eff;
    assign row_end = (row_ext + DIM_W'(1)) == h_eff;

    assign addr_full = (32'(orow_reg) + 32'(row_reg)) * 32'(rvf_pkg::LINE_PIXELS)
                     + 32'(ocol_reg) + 32'(col_reg);

    always_comb
    begin
        push_item.pixel   = pixel_in;
        push_item.dx      = (col_ext > DIM_W'(cx)) ? POS_W'(col_ext - DIM_W'(cx))
                                                   : POS_W'(DIM_W'(cx) - col_ext);
        push_item.dy      = (row_ext > DIM_W'(cy)) ? POS_W'(row_ext - DIM_W'(cy))
                                                   : POS_W'(DIM_W'(cy) - row_ext);
        push_item.cx      = cx;
        push_item.cy      = cy;
        push_item.address = addr_full[rvf_pkg::ADDR_W-1:0];
        push_item.last    = col_end && row_end;
    end

    // Advance the raster position; a dimension write restarts the image
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        ocol_next   = ocol_reg;
        orow_next   = orow_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        if (accept) begin
            if (col_end) begin
                col_next = '0;
                row_next = row_end ? '0 : row_reg + POS_W'(1);
            end else begin
                col_next = col_reg + POS_W'(1);
            end
        end
        if (cfg_wr) begin
            unique case (cfg_idx)
                rvf_pkg::CFG_IMAGE_WIDTH:
                begin
                    width_next = pwdata[rvf_pkg::DIM_CFG_W-1:0];
                    col_next   = '0;
                    row_next   = '0;
                end
                rvf_pkg::CFG_IMAGE_HEIGHT:
                begin
                    height_next = pwdata[rvf_pkg::DIM_CFG_W-1:0];
                    col_next    = '0;
                    row_next    = '0;
                end
                rvf_pkg::CFG_ORIGIN_COL: ocol_next = pwdata[rvf_pkg::ORIGIN_W-1:0];
                rvf_pkg::CFG_ORIGIN_ROW: orow_next = pwdata[rvf_pkg::ORIGIN_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            width_reg  <= rvf_pkg::DIM_CFG_W'(64);
            height_reg <= rvf_pkg::DIM_CFG_W'(64);
            ocol_reg   <= '0;
            orow_reg   <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            ocol_reg   <= ocol_next;
            orow_reg   <= orow_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

`include "rgb565_vignette_filter_top_assert.svh"

    `RVF_ASSERT_NOW(a_pos_in_image, clk, rst_n, 1'b1, (col_ext < w_eff) && (row_ext < h_eff), "position outside image")
    `RVF_ASSERT_NEXT(a_last_wraps, clk, rst_n, accept && push_item.last, (col_reg == '0) && (row_reg == '0), "position not reset after last pixel")

endmodule

/* hdl/rvf_queue.sv */
// ----------------------------------------------------------------------------
// rvf_queue
// Short register queue decoupling the front classifier from the back
// datapath.
// ----------------------------------------------------------------------------
module rvf_queue
#(
    parameter int DEPTH = rvf_pkg::QUEUE_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rvf_pkg::rvf_item_t  push_item,
    input  logic                pop,
    output rvf_pkg::rvf_item_t  pop_item,
    output rvf_pkg::rvf_qstat_t qstat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rvf_pkg::rvf_item_t mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign qstat.empty = (count_reg == '0);
    assign qstat.full  = (count_reg == CNT_W'(DEPTH));
    assign pop_item    = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

`include "rgb565_vignette_filter_top_assert.svh"

    `RVF_ASSERT_NEXT(a_q_grow, clk, rst_n, push && !pop, count_reg == $past(count_reg) + CNT_W'(1), "queue count did not grow on push")
    `RVF_ASSERT_NEXT(a_q_shrink, clk, rst_n, pop && !push, count_reg == $past(count_reg) - CNT_W'(1), "queue count did not shrink on pop")
    `RVF_ASSERT_NOW(a_q_no_underflow, clk, rst_n, pop, !qstat.empty, "pop from empty queue")

endmodule

/* hdl/rvf_back.sv */
// ----------------------------------------------------------------------------
// rvf_back
// Pixel datapath: RGB to YUV, radial luma scaling, YUV to RGB565, with a
// stall-all pipeline ending in the output register.
// ----------------------------------------------------------------------------
module rvf_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  rvf_pkg::rvf_qstat_t           qstat,
    input  rvf_pkg::rvf_item_t            pop_item,
    output logic                          pop,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [rvf_pkg::PIXEL_W-1:0]   pixel_out,
    output logic [rvf_pkg::ADDR_W-1:0]    pixel_address,
    output logic                          last_of_image
);

    localparam int POS_W  = rvf_pkg::POS_W;
    localparam int HALF_W = rvf_pkg::HALF_W;
    localparam int ADDR_W = rvf_pkg::ADDR_W;
    localparam int SUM_W  = 18;
    localparam int SQ_W   = 2 * POS_W;
    localparam int HSQ_W  = 2 * HALF_W;
    localparam int RR_W   = SQ_W + 1;
    localparam int DIFF_W = HSQ_W + 1;
    localparam int D2_W   = 2 * DIFF_W;
    localparam int PROD_W = 8 + D2_W;
    localparam int YS_W   = PROD_W - rvf_pkg::LUMA_SHIFT;
    localparam int CW     = YS_W + 10;

    localparam logic signed [SUM_W-1:0] K_YR = SUM_W'(38);
    localparam logic signed [SUM_W-1:0] K_YG = SUM_W'(75);
    localparam logic signed [SUM_W-1:0] K_YB = SUM_W'(15);
    localparam logic signed [SUM_W-1:0] K_UR = SUM_W'(22);
    localparam logic signed [SUM_W-1:0] K_UG = SUM_W'(42);
    localparam logic signed [SUM_W-1:0] K_UB = SUM_W'(64);
    localparam logic signed [SUM_W-1:0] K_VR = SUM_W'(64);
    localparam logic signed [SUM_W-1:0] K_VG = SUM_W'(54);
    localparam logic signed [SUM_W-1:0] K_VB = SUM_W'(10);
    localparam logic signed [CW-1:0]    K_Y  = CW'(128);
    localparam logic signed [CW-1:0]    K_RV = CW'(178);
    localparam logic signed [CW-1:0]    K_GU = CW'(44);
    localparam logic signed [CW-1:0]    K_GV = CW'(91);
    localparam logic signed [CW-1:0]    K_BU = CW'(227);

    // Clamp to 0..255
    function automatic logic [7:0] clip_byte(input logic signed [CW-1:0] x);
        logic [7:0] res;
        if (x < 0) begin
            res = 8'd0;
        end else if (x > 255) begin
            res = 8'd255;
        end else begin
            res = x[7:0];
        end
        return res;
    endfunction

    // Clamp to -128..127
    function automatic logic signed [7:0] clip_sbyte(input logic signed [SUM_W-1:0] x);
        logic signed [7:0] res;
        if (x < -128) begin
            res = -8'sd128;
        end else if (x > 127) begin
            res = 8'sd127;
        end else begin
            res = x[7:0];
        end
        return res;
    endfunction

    logic advance;
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;

    // Stage 1: widened channels, YUV sums, squared offsets
    logic [7:0]              r8, g8, b8;
    logic signed [SUM_W-1:0] rs, gs, bs;
    logic signed [SUM_W-1:0] ysum1_reg, usum1_reg, vsum1_reg;
    logic [SQ_W-1:0]         dx2_1_reg, dy2_1_reg;
    logic [HSQ_W-1:0]        cx2_1_reg, cy2_1_reg;
    logic [ADDR_W-1:0]       addr1_reg;
    logic                    last1_reg;

    // Stage 2: clipped YUV, radial difference
    logic signed [SUM_W-1:0] ysh, ush, vsh;
    logic [7:0]              ytmp;
    logic [RR_W-1:0]         full_ext, rr;
    logic [7:0]              y2_reg;
    logic signed [7:0]       u2_reg, v2c_reg;
    logic [DIFF_W-1:0]       diff2_reg;
    logic [ADDR_W-1:0]       addr2_reg;
    logic                    last2_reg;

    // Stage 3: squared difference
    logic [7:0]              y3_reg;
    logic signed [7:0]       u3_reg, v3c_reg;
    logic [D2_W-1:0]         dsq3_reg;
    logic [ADDR_W-1:0]       addr3_reg;
    logic                    last3_reg;

    // Stage 4: scaled luma
    logic [PROD_W-1:0]       prod;
    logic [YS_W-1:0]         y4_reg;
    logic signed [7:0]       u4_reg, v4c_reg;
    logic [ADDR_W-1:0]       addr4_reg;
    logic                    last4_reg;

    // Output stage
    logic signed [CW-1:0]    ys, us, vs, rsum, gsum, bsum;
    logic [7:0]              ro, go, bo;
    logic [rvf_pkg::PIXEL_W-1:0] pix_out_reg;
    logic [ADDR_W-1:0]       addr_out_reg;
    logic                    last_out_reg;

    // Move the whole pipe whenever the output register is free or taken
    assign advance = !out_valid_reg || result_ready;
    assign pop     = advance && !qstat.empty;

    assign r8 = {pop_item.pixel[15:11], 3'b111};
    assign g8 = {pop_item.pixel[10:5], 2'b11};
    assign b8 = {pop_item.pixel[4:0], 3'b111};
    assign rs = SUM_W'(r8);
    assign gs = SUM_W'(g8);
    assign bs = SUM_W'(b8);

    assign ysh      = ysum1_reg >>> 7;
    assign ush      = usum1_reg >>> 7;
    assign vsh      = vsum1_reg >>> 7;
    assign ytmp     = clip_byte(CW'(ysh));
    assign full_ext = RR_W'(cx2_1_reg) + RR_W'(cy2_1_reg);
    assign rr       = RR_W'(dx2_1_reg) + RR_W'(dy2_1_reg);

    assign prod = PROD_W'(y3_reg) * PROD_W'(dsq3_reg);

    assign ys   = CW'(y4_reg);
    assign us   = CW'(u4_reg);
    assign vs   = CW'(v4c_reg);
    assign rsum = (ys * K_Y + vs * K_RV) >>> 7;
    assign gsum = (ys * K_Y - us * K_GU - vs * K_GV) >>> 7;
    assign bsum = (ys * K_Y + us * K_BU) >>> 7;
    assign ro   = clip_byte(rsum);
    assign go   = clip_byte(gsum);
    assign bo   = clip_byte(bsum);

    // Hold stage valids while the output is stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            v1_reg        <= !qstat.empty;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg;
        end
    end

    // Advance the payload through the stages
    always_ff @(posedge clk)
    begin
        if (advance) begin
            ysum1_reg <= K_YR * rs + K_YG * gs + K_YB * bs;
            usum1_reg <= K_UB * bs - K_UR * rs - K_UG * gs;
            vsum1_reg <= K_VR * rs - K_VG * gs - K_VB * bs;
            dx2_1_reg <= SQ_W'(pop_item.dx) * SQ_W'(pop_item.dx);
            dy2_1_reg <= SQ_W'(pop_item.dy) * SQ_W'(pop_item.dy);
            cx2_1_reg <= HSQ_W'(pop_item.cx) * HSQ_W'(pop_item.cx);
            cy2_1_reg <= HSQ_W'(pop_item.cy) * HSQ_W'(pop_item.cy);
            addr1_reg <= pop_item.address;
            last1_reg <= pop_item.last;

            y2_reg    <= ytmp;
            u2_reg    <= clip_sbyte(ush);
            v2c_reg   <= clip_sbyte(vsh);
            diff2_reg <= (full_ext >= rr) ? DIFF_W'(full_ext - rr) : '0;
            addr2_reg <= addr1_reg;
            last2_reg <= last1_reg;

            y3_reg    <= y2_reg;
            u3_reg    <= u2_reg;
            v3c_reg   <= v2c_reg;
            dsq3_reg  <= D2_W'(diff2_reg) * D2_W'(diff2_reg);
            addr3_reg <= addr2_reg;
            last3_reg <= last2_reg;

            y4_reg    <= YS_W'(prod >> rvf_pkg::LUMA_SHIFT);
            u4_reg    <= u3_reg;
            v4c_reg   <= v3c_reg;
            addr4_reg <= addr3_reg;
            last4_reg <= last3_reg;

            pix_out_reg  <= {ro[7:3], go[7:2], bo[7:3]};
            addr_out_reg <= addr4_reg;
            last_out_reg <= last4_reg;
        end
    end

    assign result_valid  = out_valid_reg;
    assign pixel_out     = pix_out_reg;
    assign pixel_address = addr_out_reg;
    assign last_of_image = last_out_reg;

endmodule

/* hdl/rgb565_vignette_filter_top.sv */
// ----------------------------------------------------------------------------
// rgb565_vignette_filter_top
// Streams RGB565 pixels in raster order and darkens luma with the squared
// complement of each pixel's squared distance from the image center.
// Sustained rate is one pixel per clock while the output is not stalled;
// accepted pixels pass through the classifier queue into the five-stage
// back datapath, which ends in the output register. A write to
// image_width or image_height restarts the raster position; origin writes
// keep it. Registers: image_width at 0x0, image_height at 0x4,
// origin_col at 0x8, origin_row at 0xC, all readable. pixel_address is
// (origin_row + row) * 1024 + origin_col + column, wrapped to 20 bits.
// ----------------------------------------------------------------------------
module rgb565_vignette_filter_top
#(
    parameter int QUEUE_DEPTH = rvf_pkg::QUEUE_DEPTH
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rvf_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [rvf_pkg::DATA_W-1:0]      pwdata,
    output logic [rvf_pkg::DATA_W-1:0]      prdata,
    output logic                            pready,
    input  logic                            pixel_valid,
    output logic                            pixel_ready,
    input  logic [rvf_pkg::PIXEL_W-1:0]     pixel_in,
    output logic                            result_valid,
    input  logic                            result_ready,
    output logic [rvf_pkg::PIXEL_W-1:0]     pixel_out,
    output logic [rvf_pkg::ADDR_W-1:0]      pixel_address,
    output logic                            last_of_image
);

    rvf_pkg::rvf_qstat_t qstat;
    rvf_pkg::rvf_item_t  push_item;
    rvf_pkg::rvf_item_t  pop_item;
    logic                push;
    logic                pop;

    // Classify pixels and hold configuration
    rvf_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel_in    (pixel_in),
        .qstat       (qstat),
        .push        (push),
        .push_item   (push_item)
    );

    // Buffer classified items
    rvf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .qstat     (qstat)
    );

    // Filter and deliver results
    rvf_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .qstat         (qstat),
        .pop_item      (pop_item),
        .pop           (pop),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .pixel_out     (pixel_out),
        .pixel_address (pixel_address),
        .last_of_image (last_of_image)
    );

endmodule

/* sim/tb_rgb565_vignette_filter_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb565_vignette_filter_top
// Streams RGB565 pixels through the vignette filter over a series of image
// geometries and VRAM origins set on the APB port. Pixel and result sides
// idle and stall at random. A scoreboard predicts each filtered pixel, its
// VRAM offset and the end-of-image flag, and compares them in order.
// ----------------------------------------------------------------------------
module tb_rgb565_vignette_filter_top;

    import rvf_pkg::*;

    localparam int IDLE_LIMIT    = 2000;
    localparam int RANDOM_PIXELS = 1050;
    localparam int CALM_FROM     = 900;
    localparam int SETTLE_CYCLES = 10;

    typedef struct {
        logic [PIXEL_W-1:0] pixel;
        logic [ADDR_W-1:0]  address;
        logic               last;
    } vignette_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the registers and raster position, predicts results
    // ------------------------------------------------------------------------
    class vignette_scoreboard;
        logic [DIM_CFG_W-1:0] width_reg;
        logic [DIM_CFG_W-1:0] height_reg;
        logic [ORIGIN_W-1:0]  col_origin;
        logic [ORIGIN_W-1:0]  row_origin;
        int unsigned          col_pos;
        int unsigned          row_pos;
        vignette_result_t     expected_pixels[$];
        int                   errors;

        function new();
            width_reg  = 8'd64;
            height_reg = 8'd64;
            col_origin = '0;
            row_origin = '0;
            col_pos    = 0;
            row_pos    = 0;
            errors     = 0;
        endfunction

        // Zero counts as one, anything above the maximum as the maximum
        static function int unsigned usable_dim(logic [DIM_CFG_W-1:0] v);
            if (v == 0)
                return 1;
            return (v > MAX_DIM) ? MAX_DIM : v;
        endfunction

        static function longint clip(longint x, longint lo, longint hi);
            return (x < lo) ? lo : ((x > hi) ? hi : x);
        endfunction

        // Dimension writes restart the raster, origin writes keep it
        function void write_reg(rvf_cfg_t idx, logic [DATA_W-1:0] value);
            case (idx)
                CFG_IMAGE_WIDTH:
                begin
                    width_reg = value[DIM_CFG_W-1:0];
                    col_pos   = 0;
                    row_pos   = 0;
                end
                CFG_IMAGE_HEIGHT:
                begin
                    height_reg = value[DIM_CFG_W-1:0];
                    col_pos    = 0;
                    row_pos    = 0;
                end
                CFG_ORIGIN_COL: col_origin = value[ORIGIN_W-1:0];
                CFG_ORIGIN_ROW: row_origin = value[ORIGIN_W-1:0];
                default: ;
            endcase
        endfunction

        function void check_reg(rvf_cfg_t idx, logic [DATA_W-1:0] rd);
            logic [DATA_W-1:0] want;
            case (idx)
                CFG_IMAGE_WIDTH:  want = DATA_W'(width_reg);
                CFG_IMAGE_HEIGHT: want = DATA_W'(height_reg);
                CFG_ORIGIN_COL:   want = DATA_W'(col_origin);
                default:          want = DATA_W'(row_origin);
            endcase
            if (rd !== want)
            begin
                $error("prdata: expected %0h, got %0h", want, rd);
                errors++;
            end
        endfunction

        // Predict the result of one accepted pixel and advance the raster
        function void note_pixel(logic [PIXEL_W-1:0] px);
            int unsigned      w, h, col, row, cx, cy, dx, dy;
            longint           r, g, b, y, u, v, full, rr, diff;
            vignette_result_t res;

            w = usable_dim(width_reg);
            h = usable_dim(height_reg);
            if (col_pos >= w)
                col_pos = 0;
            if (row_pos >= h)
                row_pos = 0;
            col = col_pos;
            row = row_pos;

            // widen to 8 bits per channel, dropped bits filled with ones
            r = longint'({px[15:11], 3'b111});
            g = longint'({px[10:5], 2'b11});
            b = longint'({px[4:0], 3'b111});

            y = clip((38 * r + 75 * g + 15 * b) >>> 7, 0, 255);
            u = clip((-22 * r - 42 * g + 64 * b) >>> 7, -128, 127);
            v = clip((64 * r - 54 * g - 10 * b) >>> 7, -128, 127);

            // scale luma by the squared complement of the squared radius
            cx   = w / 2;
            cy   = h / 2;
            dx   = (col > cx) ? col - cx : cx - col;
            dy   = (row > cy) ? row - cy : cy - row;
            full = longint'(cx * cx + cy * cy);
            rr   = longint'(dx * dx + dy * dy);
            diff = (full >= rr) ? full - rr : 0;
            y    = (y * diff * diff) >>> LUMA_SHIFT;

            r = clip((128 * y + 178 * v) >>> 7, 0, 255);
            g = clip((128 * y - 44 * u - 91 * v) >>> 7, 0, 255);
            b = clip((128 * y + 227 * u) >>> 7, 0, 255);

            res.pixel   = {r[7:3], g[7:2], b[7:3]};
            res.address = ADDR_W'((row_origin + row) * LINE_PIXELS + col_origin + col);
            res.last    = (col + 1 == w) && (row + 1 == h);
            expected_pixels.push_back(res);

            if (col + 1 >= w)
            begin
                col_pos = 0;
                row_pos = (row + 1 >= h) ? 0 : row + 1;
            end
            else
            begin
                col_pos = col + 1;
            end
        endfunction

        // Compare one accepted result with the oldest prediction
        function void check_pixel(logic [PIXEL_W-1:0] px, logic [ADDR_W-1:0] addr, logic last);
            vignette_result_t want;
            if (expected_pixels.size() == 0)
            begin
                $error("unexpected result: pixel_out %h, pixel_address %h", px, addr);
                errors++;
                return;
            end
            want = expected_pixels.pop_front();
            if (px !== want.pixel)
            begin
                $error("pixel_out: expected %h, got %h", want.pixel, px);
                errors++;
            end
            if (addr !== want.address)
            begin
                $error("pixel_address: expected %h, got %h", want.address, addr);
                errors++;
            end
            if (last !== want.last)
            begin
                $error("last_of_image: expected %b, got %b", want.last, last);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and block under test
    // ------------------------------------------------------------------------
    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr        = '0;
    logic [DATA_W-1:0]     pwdata       = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;
    logic                  pixel_valid  = 1'b0;
    logic                  pixel_ready;
    logic [PIXEL_W-1:0]    pixel_in     = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    logic [PIXEL_W-1:0]    pixel_out;
    logic [ADDR_W-1:0]     pixel_address;
    logic                  last_of_image;

    vignette_scoreboard sb;
    bit                 calm = 1'b0;
    int                 quiet_cycles = 0;

    rgb565_vignette_filter_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .pixel_valid   (pixel_valid),
        .pixel_ready   (pixel_ready),
        .pixel_in      (pixel_in),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .pixel_out     (pixel_out),
        .pixel_address (pixel_address),
        .last_of_image (last_of_image)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Monitor: note accepted pixels, check accepted results, count quiet cycles
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pixel_valid && pixel_ready)
                sb.note_pixel(pixel_in);
            if (result_valid && result_ready)
                sb.check_pixel(pixel_out, pixel_address, last_of_image);
            if ((pixel_valid && pixel_ready) || (result_valid && result_ready)
                || (psel && penable && pready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // Stop a hung run
    initial
    begin
        wait (rst_n);
        while (quiet_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("DONE: errors detected");
        $finish;
    end

    // Result side: random stall bursts, none once the run turns calm
    initial
    begin
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 4) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            result_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Write a register with random upper bits, then read it back
    task automatic cfg_write(input rvf_cfg_t idx, input int unsigned field);
        logic [DATA_W-1:0] value;
        value = $urandom;
        if (idx == CFG_IMAGE_WIDTH || idx == CFG_IMAGE_HEIGHT)
            value[DIM_CFG_W-1:0] = field[DIM_CFG_W-1:0];
        else
            value[ORIGIN_W-1:0] = field[ORIGIN_W-1:0];

        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.write_reg(idx, value);

        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.check_reg(idx, prdata);

        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_geometry(input int unsigned w, input int unsigned h,
                                input int unsigned oc, input int unsigned orow);
        cfg_write(CFG_IMAGE_WIDTH, w);
        cfg_write(CFG_IMAGE_HEIGHT, h);
        cfg_write(CFG_ORIGIN_COL, oc);
        cfg_write(CFG_ORIGIN_ROW, orow);
    endtask

    // Offer one pixel, maybe after a gap, and hold it until accepted
    task automatic push_pixel(input logic [PIXEL_W-1:0] px);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            pixel_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel_in    <= px;
        do @(posedge clk); while (!pixel_ready);
    endtask

    // Drop valid, let the monitor note the last item, then hold until every
    // predicted result has come back
    task automatic drain();
        pixel_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [PIXEL_W-1:0] pick_pixel();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return PIXEL_W'($urandom);
        endcase
    endfunction

    function automatic int unsigned pick_dim();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 1;
            2:       return MAX_DIM;
            3:       return $urandom_range(MAX_DIM + 1, 255);
            default: return $urandom_range(2, 16);
        endcase
    endfunction

    function automatic int unsigned pick_origin();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 1023;
            default: return $urandom_range(0, 1023);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        logic [PIXEL_W-1:0] corner_pixels[7];
        int                 random_sent;
        int                 n;
        int unsigned        area;

        sb = new();
        corner_pixels = '{16'h0000, 16'hFFFF, 16'hF800, 16'h07E0,
                          16'h001F, 16'h5555, 16'hAAAA};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Start of a 64x64 image at reset geometry: channel extremes
        foreach (corner_pixels[i])
            push_pixel(corner_pixels[i]);
        drain();

        // Zero width as one column, far origin: second row wraps the offset
        set_geometry(0, 2, 1023, 1023);
        repeat (4) push_pixel(pick_pixel());
        drain();

        // Oversized width clamps, zero height as one row
        set_geometry(255, 0, 1023, 5);
        repeat (3) push_pixel(pick_pixel());
        drain();

        // Origin move mid-image keeps the raster position
        set_geometry(3, 2, 0, 0);
        repeat (4) push_pixel(pick_pixel());
        drain();
        cfg_write(CFG_ORIGIN_COL, 5);
        repeat (3) push_pixel(pick_pixel());
        drain();

        // A wide single-row strip drives scaled luma well above 255 mid-row
        random_sent = 0;
        set_geometry(MAX_DIM, 1, $urandom_range(0, 1023), $urandom_range(0, 1023));
        repeat (MAX_DIM) push_pixel(pick_pixel());
        random_sent += MAX_DIM;
        drain();

        // Random phases: whole images for small geometries, partial ones otherwise
        while (random_sent < RANDOM_PIXELS)
        begin
            if (random_sent >= CALM_FROM)
                calm = 1'b1;
            if ($urandom_range(0, 4) == 0)
            begin
                cfg_write(CFG_ORIGIN_COL, pick_origin());
                cfg_write(CFG_ORIGIN_ROW, pick_origin());
            end
            else
            begin
                set_geometry(pick_dim(), pick_dim(), pick_origin(), pick_origin());
            end
            area = vignette_scoreboard::usable_dim(sb.width_reg)
                 * vignette_scoreboard::usable_dim(sb.height_reg);
            if (area <= 60)
                n = area * $urandom_range(1, 3) + $urandom_range(0, 2);
            else
                n = $urandom_range(20, 150);
            repeat (n) push_pixel(pick_pixel());
            random_sent += n;
            drain();
        end

        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
